[rtl/stsi_pkg.sv]
// Shared types and constants for the sorted table.
package stsi_pkg;

	localparam int DEF_CAPACITY = 32;
	localparam int VAL_W        = 32;
	localparam int POS_W        = 6;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		mode_t                   mode;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t                 status;
		logic [POS_W-1:0]        position;
		logic [POS_W-1:0]        fill_count;
		logic signed [VAL_W-1:0] min_value;
		logic signed [VAL_W-1:0] max_value;
	} result_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                    ins_en;
		logic                    del_en;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

[rtl/sorted_table_insert_delete_search.sv]
// Top level of the sorted table: a row of compare-and-shift cells plus control.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------
//   command | start / busy       | cmd    (cmd_t)
//   result  | done (strobe)      | result (result_t)
//
// One command per cycle: every cell compares the broadcast word with its own
// entry and shifts in the same cycle, so busy stays low.
// The result strobes on done in the cycle after the command is taken.
// Reset clears the fill count; entries stay unset until written.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sorted_table_insert_delete_search import stsi_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	status_t          status_q;
	logic [CNT_W-1:0] pos_q;

	cell_ctl_t               ctl;
	logic signed [VAL_W-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0]     lt, bnd, hit, last;

	logic             full, empty, found, do_ins, do_del;
	status_t          status_d;
	logic [CNT_W-1:0] pos_at, pos_d;
	logic signed [VAL_W-1:0] max_or;
	logic [CNT_W+POS_W-1:0]  cnt_ext, pos_ext;

	assign busy  = 1'b0;
	assign full  = count_q == CAP_C;
	assign empty = count_q == '0;
	assign found = |hit;

	assign do_ins = start && (cmd.mode == MODE_INSERT) && !full;
	assign do_del = start && (cmd.mode == MODE_DELETE) && found;

	assign ctl.ins_en = do_ins;
	assign ctl.del_en = do_del;
	assign ctl.value  = cmd.value;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		stsi_cell #(
			.IDX   (k),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.left_lt     ((k == 0) ? 1'b1 : lt[(k == 0) ? 0 : k-1]),
			.left_entry  ((k == 0) ? cmd.value : entry[(k == 0) ? 0 : k-1]),
			.right_entry ((k == CAPACITY-1) ? entry[k] : entry[(k == CAPACITY-1) ? k : k+1]),
			.entry       (entry[k]),
			.lt          (lt[k]),
			.bnd         (bnd[k]),
			.hit         (hit[k]),
			.last        (last[k])
		);
	end

	// encode the one-hot boundary and pick the last stored entry
	always_comb begin
		pos_at = '0;
		max_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (bnd[k]) pos_at = pos_at | CNT_W'(k + 1);
			if (last[k]) max_or = max_or | entry[k];
		end
	end

	always_comb begin
		status_d = ST_DONE;
		pos_d    = '0;
		unique case (cmd.mode) inside
			MODE_INSERT: begin
				if (full) status_d = ST_FULL;
				else pos_d = pos_at;
			end
			MODE_DELETE, MODE_SEARCH: begin
				if (empty) status_d = ST_EMPTY;
				else if (found) pos_d = pos_at;
				else status_d = ST_MISSING;
			end
			MODE_CLEAR: begin
				status_d = ST_DONE;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= start;
			if (start && cmd.mode == MODE_CLEAR) count_q <= '0;
			else if (do_ins) count_q <= count_q + CNT_W'(1);
			else if (do_del) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			status_q <= status_d;
			pos_q    <= pos_d;
		end
	end

	// report position and count modulo 64
	assign cnt_ext = {{POS_W{1'b0}}, count_q};
	assign pos_ext = {{POS_W{1'b0}}, pos_q};

	assign done              = done_q;
	assign result.status     = status_q;
	assign result.position   = pos_ext[POS_W-1:0];
	assign result.fill_count = cnt_ext[POS_W-1:0];
	assign result.min_value  = empty ? '0 : entry[0];
	assign result.max_value  = max_or;

endmodule

[rtl/stsi_cell.sv]
// One table slot: holds an entry, compares it with the broadcast word, shifts.
module stsi_cell import stsi_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 6
) (
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  logic [CNT_W-1:0]        count,
	input  logic                    left_lt,
	input  logic signed [VAL_W-1:0] left_entry,
	input  logic signed [VAL_W-1:0] right_entry,
	output logic signed [VAL_W-1:0] entry,
	output logic                    lt,
	output logic                    bnd,
	output logic                    hit,
	output logic                    last
);

	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

	logic signed [VAL_W-1:0] entry_q;
	logic                    occ;

	assign occ   = count > IDX_C;
	assign lt    = occ && (entry_q < ctl.value);
	// first slot that is not smaller than the word
	assign bnd   = !lt && left_lt;
	assign hit   = bnd && occ && (entry_q == ctl.value);
	assign last  = count == NEXT_C;
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en && !lt) begin
			entry_q <= left_lt ? ctl.value : left_entry;
		end else if (ctl.del_en && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

[test/sorted_table_insert_delete_search_tb.sv]
// Self-checking testbench for the sorted table: queued command stream, shadow table, result check.
module sorted_table_insert_delete_search_tb import stsi_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_PRINTS   = 60;

	typedef struct {
		cmd_t word;
		int   gap_pct;
		bit   drain;
	} pending_cmd_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;

	pending_cmd_t pending_cmds[$];
	result_t      expected_results[$];

	// shadow copy of the table contents
	logic signed [VAL_W-1:0] shadow_entries[TABLE_DEPTH];
	int                      shadow_count = 0;

	logic signed [VAL_W-1:0] value_pool[8];
	int gap_now = 7;
	int items_taken = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	sorted_table_insert_delete_search #(
		.CAPACITY(TABLE_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	function automatic int first_not_below(logic signed [VAL_W-1:0] v);
		int idx;
		idx = 0;
		while (idx < shadow_count && shadow_entries[idx] < v)
			idx++;
		return idx;
	endfunction

	function automatic result_t predict_table_result(cmd_t c);
		result_t                 r;
		logic signed [VAL_W-1:0] v;
		int                      slot;
		r = '0;
		v = c.value;
		r.status = ST_DONE;
		case (c.mode) inside
		MODE_INSERT: begin
			if (shadow_count >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				slot = first_not_below(v);
				for (int j = shadow_count; j > slot; j--)
					shadow_entries[j] = shadow_entries[j-1];
				shadow_entries[slot] = v;
				shadow_count++;
				r.position = POS_W'(slot + 1);
			end
		end
		MODE_DELETE, MODE_SEARCH: begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				slot = first_not_below(v);
				if (slot < shadow_count && shadow_entries[slot] == v) begin
					r.position = POS_W'(slot + 1);
					if (c.mode == MODE_DELETE) begin
						for (int j = slot; j + 1 < shadow_count; j++)
							shadow_entries[j] = shadow_entries[j+1];
						shadow_count--;
					end
				end else begin
					r.status = ST_MISSING;
				end
			end
		end
		default: begin
			shadow_count = 0;
		end
		endcase
		r.fill_count = POS_W'(shadow_count);
		if (shadow_count != 0) begin
			r.min_value = shadow_entries[0];
			r.max_value = shadow_entries[shadow_count-1];
		end
		return r;
	endfunction

	// Driver: take the next queued word unless idling or waiting for the table to drain.
	always @(posedge clk) begin
		pending_cmd_t nxt;
		bit           go;
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(predict_table_result(cmd));
				items_taken <= items_taken + 1;
			end
			if (!start || !busy) begin
				go = 1'b0;
				if (pending_cmds.size() != 0) begin
					nxt = pending_cmds[0];
					go = 1'b1;
					if (nxt.drain && (start || items_taken != results_seen))
						go = 1'b0;
					if (go && $urandom_range(99) < nxt.gap_pct)
						go = 1'b0;
					if (go)
						pending_cmds.delete(0);
				end
				start <= go;
				if (go)
					cmd <= nxt.word;
			end
		end
	end

	// Monitor: every strobe must match the oldest outstanding prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no command outstanding",
					results_seen));
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status)
					report_mismatch($sformatf("result %0d status %0d, expected %0d",
						results_seen, result.status, want.status));
				if (result.position !== want.position)
					report_mismatch($sformatf("result %0d position %0d, expected %0d",
						results_seen, result.position, want.position));
				if (result.fill_count !== want.fill_count)
					report_mismatch($sformatf("result %0d fill_count %0d, expected %0d",
						results_seen, result.fill_count, want.fill_count));
				if (result.min_value !== want.min_value)
					report_mismatch($sformatf("result %0d min_value %0d, expected %0d",
						results_seen, result.min_value, want.min_value));
				if (result.max_value !== want.max_value)
					report_mismatch($sformatf("result %0d max_value %0d, expected %0d",
						results_seen, result.max_value, want.max_value));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_cmd(mode_t m, logic signed [VAL_W-1:0] v, bit drain = 1'b0);
		pending_cmd_t item;
		item.word.mode  = m;
		item.word.value = v;
		item.gap_pct    = gap_now;
		item.drain      = drain;
		pending_cmds.push_back(item);
	endtask

	function automatic logic signed [VAL_W-1:0] extreme_value();
		case ($urandom_range(4))
		0:       return 32'sh8000_0000;
		1:       return 32'sh7fff_ffff;
		2:       return 32'sd0;
		3:       return -32'sd1;
		default: return 32'sd1;
		endcase
	endfunction

	// mostly pool values so searches and deletes hit stored entries
	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return value_pool[$urandom_range(7)];
		else if (r < 85)
			return $urandom;
		return extreme_value();
	endfunction

	function automatic mode_t pick_mode();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return MODE_INSERT;
		else if (r < 68)
			return MODE_DELETE;
		else if (r < 97)
			return MODE_SEARCH;
		return MODE_CLEAR;
	endfunction

	initial begin
		int queued;
		int run_len;
		bit drain;

		// directed part: empty table, extremes, duplicates, misses, clear
		queue_cmd(MODE_SEARCH, 32'sd5);
		queue_cmd(MODE_DELETE, -32'sd5);
		queue_cmd(MODE_INSERT, 32'sh7fff_ffff);
		queue_cmd(MODE_INSERT, 32'sh8000_0000);
		queue_cmd(MODE_INSERT, 32'sd0);
		queue_cmd(MODE_INSERT, 32'sd0);
		queue_cmd(MODE_INSERT, -32'sd1);
		queue_cmd(MODE_INSERT, 32'sd1);
		queue_cmd(MODE_SEARCH, 32'sh8000_0000);
		queue_cmd(MODE_SEARCH, 32'sh7fff_ffff);
		queue_cmd(MODE_SEARCH, 32'sd0);
		queue_cmd(MODE_SEARCH, 32'sd12345);
		queue_cmd(MODE_DELETE, 32'sd0);
		queue_cmd(MODE_DELETE, 32'sd0);
		queue_cmd(MODE_DELETE, 32'sd0);
		queue_cmd(MODE_DELETE, 32'sh7fff_ffff);
		queue_cmd(MODE_DELETE, 32'sh8000_0000);
		queue_cmd(MODE_INSERT, 32'shaaaa_aaaa);
		queue_cmd(MODE_INSERT, 32'sh5555_5555);
		queue_cmd(MODE_CLEAR, 32'shffff_ffff);
		queue_cmd(MODE_SEARCH, -32'sd1);
		queue_cmd(MODE_DELETE, 32'sd1);
		queue_cmd(MODE_CLEAR, 32'sd0);

		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			if (queued < RANDOM_ITEMS / 3)
				gap_now = 7;
			else if (queued < 2 * RANDOM_ITEMS / 3)
				gap_now = 69;
			else
				gap_now = 0;
			foreach (value_pool[k]) begin
				case ($urandom_range(2))
				0:       value_pool[k] = $urandom;
				1:       value_pool[k] = $urandom_range(8) - 4;
				default: value_pool[k] = extreme_value();
				endcase
			end
			// hold the first random word, and now and then a later run's first word, until the table has answered everything
			drain = (queued == 0) || ($urandom_range(5) == 0);
			if ($urandom_range(3) == 0) begin
				// fill past capacity, then probe the full table
				queue_cmd(MODE_CLEAR, $urandom, drain);
				run_len = TABLE_DEPTH + $urandom_range(1, 4);
				for (int k = 0; k < run_len; k++)
					queue_cmd(MODE_INSERT, pick_value());
				queued += run_len + 1;
				run_len = $urandom_range(5, 15);
				for (int k = 0; k < run_len; k++)
					queue_cmd($urandom_range(1) ? MODE_SEARCH : MODE_DELETE, pick_value());
				queued += run_len;
			end else begin
				run_len = $urandom_range(10, 40);
				queue_cmd(pick_mode(), pick_value(), drain);
				for (int k = 1; k < run_len; k++)
					queue_cmd(pick_mode(), pick_value());
				queued += run_len;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
